// ----- hw/rtl/rcl_pkg.sv -----
// Package for the RIFF chunk locator.
// Holds the shared types, register indexes and status codes; no dependencies.
package rcl_pkg;

   localparam int unsigned RCL_BYTE_W = 8;
   localparam int unsigned RCL_WORD_W = 32;
   localparam int unsigned RCL_ADDR_W = 3;

   localparam logic [RCL_WORD_W-1:0] RCL_TARGET_RESET = 32'h2074_6d66;
   localparam logic [RCL_WORD_W-1:0] RCL_LENGTH_RESET = 32'h0000_0000;

   localparam logic RCL_REG_TARGET = 1'b0;
   localparam logic RCL_REG_LENGTH = 1'b1;

   localparam logic RCL_FOUND     = 1'b0;
   localparam logic RCL_NOT_FOUND = 1'b1;

   localparam logic [2:0] RCL_LAST_HDR_BYTE = 3'd7;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_SKIP   = 3'b010,
      PH_DONE   = 3'b100
   } rcl_phase_type;

   typedef struct packed {
      logic [RCL_BYTE_W-1:0] data_byte;
      logic                  first;
   } rcl_byte_type;

   typedef struct packed {
      logic                  status;
      logic [RCL_WORD_W-1:0] chunk_size;
      logic [RCL_WORD_W-1:0] payload_offset;
   } rcl_result_type;

   typedef struct packed {
      logic [RCL_WORD_W-1:0] target_fourcc;
      logic [RCL_WORD_W-1:0] body_length;
   } rcl_cfg_type;

endpackage

// ----- hw/rtl/rcl_req_if.sv -----
// Byte channel into the RIFF chunk locator: valid/ready plus one body word.
// Depends on rcl_pkg for field widths.
interface rcl_req_if import rcl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [RCL_BYTE_W-1:0] data_byte;
   logic                  first;

   modport source (output valid, output data_byte, output first, input ready);
   modport sink (input valid, input data_byte, input first, output ready);
endinterface

// ----- hw/rtl/rcl_rsp_if.sv -----
// Result channel out of the RIFF chunk locator: valid/ready plus one result word.
// Depends on rcl_pkg for field widths.
interface rcl_rsp_if import rcl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  status;
   logic [RCL_WORD_W-1:0] chunk_size;
   logic [RCL_WORD_W-1:0] payload_offset;

   modport source (output valid, output status, output chunk_size,
                   output payload_offset, input ready);
   modport sink (input valid, input status, input chunk_size,
                 input payload_offset, output ready);
endinterface

// ----- hw/rtl/rcl_walker.sv -----
// Chunk walk state and the per-byte step of the RIFF chunk locator.
// Depends on rcl_pkg for the phase type, byte, result and config structs.
module rcl_walker import rcl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  rcl_byte_type   in_word,
   input  rcl_cfg_type    cfg,
   output logic           hit,
   output rcl_result_type result
);

   rcl_phase_type         phase_ff, phase_in, phase_eff;
   logic [2:0]            hidx_ff, hidx_in, hidx_eff;
   logic [RCL_WORD_W-1:0] code_ff, code_in, code_eff;
   logic [RCL_WORD_W-1:0] size_ff, size_in, size_eff, size_next;
   logic [RCL_WORD_W-1:0] skip_ff, skip_in, skip_eff;
   logic [RCL_WORD_W-1:0] pos_ff, pos_in, pos_eff;
   logic [RCL_WORD_W:0]   next_start;

   always_comb begin
      if (in_word.first) begin
         phase_eff = PH_HEADER;
         hidx_eff  = '0;
         code_eff  = '0;
         size_eff  = '0;
         skip_eff  = '0;
         pos_eff   = '0;
      end else begin
         phase_eff = phase_ff;
         hidx_eff  = hidx_ff;
         code_eff  = code_ff;
         size_eff  = size_ff;
         skip_eff  = skip_ff;
         pos_eff   = pos_ff;
      end

      phase_in   = phase_eff;
      hidx_in    = hidx_eff;
      code_in    = code_eff;
      size_in    = size_eff;
      skip_in    = skip_eff;
      pos_in     = pos_eff;
      hit        = 1'b0;
      result     = '0;
      size_next  = {in_word.data_byte, size_eff[RCL_WORD_W-1:RCL_BYTE_W]};
      next_start = {1'b0, pos_eff} + {{RCL_WORD_W{1'b0}}, 1'b1} + {1'b0, size_next};

      case (phase_eff)
         PH_DONE: begin
         end
         PH_SKIP: begin
            pos_in = pos_eff + 32'd1;
            if (skip_eff != '0) begin
               skip_in = skip_eff - 32'd1;
            end
            if (skip_in == '0) begin
               phase_in = PH_HEADER;
            end
         end
         PH_HEADER: begin
            pos_in = pos_eff + 32'd1;
            if (hidx_eff == '0 && pos_eff >= cfg.body_length) begin
               hit           = 1'b1;
               result.status = RCL_NOT_FOUND;
               phase_in      = PH_DONE;
            end else begin
               if (!hidx_eff[2]) begin
                  code_in = {in_word.data_byte, code_eff[RCL_WORD_W-1:RCL_BYTE_W]};
               end else begin
                  size_in = size_next;
               end
               if (hidx_eff != RCL_LAST_HDR_BYTE) begin
                  hidx_in = hidx_eff + 3'd1;
               end else begin
                  hidx_in = '0;
                  if (code_eff == cfg.target_fourcc) begin
                     hit                   = 1'b1;
                     result.status         = RCL_FOUND;
                     result.chunk_size     = size_next;
                     result.payload_offset = pos_eff + 32'd1;
                     phase_in              = PH_DONE;
                  end else if (next_start >= {1'b0, cfg.body_length}) begin
                     hit           = 1'b1;
                     result.status = RCL_NOT_FOUND;
                     phase_in      = PH_DONE;
                  end else begin
                     skip_in  = size_next;
                     phase_in = (size_next == '0) ? PH_HEADER : PH_SKIP;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hidx_ff  <= '0;
         code_ff  <= '0;
         size_ff  <= '0;
         skip_ff  <= '0;
         pos_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         hidx_ff  <= hidx_in;
         code_ff  <= code_in;
         size_ff  <= size_in;
         skip_ff  <= skip_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

// ----- hw/rtl/riff_chunk_locator_top.sv -----
// Top level of the RIFF chunk locator: APB register file, input and result stages.
// Depends on rcl_pkg, rcl_req_if, rcl_rsp_if and rcl_walker.
//
// Usage:
//   req_ch carries the RIFF body one byte per word; first = 1 marks body
//   offset 0 and restarts the chunk walk. rsp_ch carries at most one result
//   per walk: status 0 with chunk size and payload offset when the chunk whose
//   code equals target_fourcc is found, status 1 when the body runs out.
//   Later bytes are dropped until the next first = 1.
//   The APB port holds target_fourcc (address 0) and body_length (address 4);
//   write them only while no byte is in flight.
//   A word accepted into the input stage is stepped by the walker when the
//   result stage can advance, which registers its result onto rsp_ch.
//   Throughput is one byte per cycle, set by the walker step, except while
//   rsp_ch stalls with a result pending: then, if the input stage is empty,
//   one more byte is taken into it and req_ch.ready drops until the result is taken.
//   Reset (synchronous) loads target_fourcc = "fmt ", body_length = 0, and
//   puts the walk at body offset 0 with both stages empty.
module riff_chunk_locator_top import rcl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rcl_req_if.sink               req_ch,
   rcl_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [RCL_ADDR_W-1:0] paddr,
   input  logic [RCL_WORD_W-1:0] pwdata,
   output logic [RCL_WORD_W-1:0] prdata,
   output logic                  pready
);

   rcl_cfg_type    cfg_ff, cfg_in;
   logic           in_valid_ff, in_valid_in;
   rcl_byte_type   in_word_ff, in_word_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rcl_result_type rsp_ff, rsp_in;
   logic           advance, step, hit, req_take;
   rcl_result_type result;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == RCL_REG_LENGTH) ? cfg_ff.body_length : cfg_ff.target_fourcc;

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (paddr[2])
            RCL_REG_TARGET: cfg_in.target_fourcc = pwdata;
            RCL_REG_LENGTH: cfg_in.body_length   = pwdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_valid_in          = 1'b1;
         in_word_in.data_byte = req_ch.data_byte;
         in_word_in.first     = req_ch.first;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = step && hit;
         if (step && hit) begin
            rsp_in = result;
         end
      end
   end

   rcl_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_word (in_word_ff),
      .cfg     (cfg_ff),
      .hit     (hit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_fourcc <= RCL_TARGET_RESET;
         cfg_ff.body_length   <= RCL_LENGTH_RESET;
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.chunk_size     = rsp_ff.chunk_size;
   assign rsp_ch.payload_offset = rsp_ff.payload_offset;

endmodule

// ----- test/riff_chunk_locator_top_test.sv -----
// Self-checking bench for riff_chunk_locator_top: walks RIFF bodies through req_ch and
// checks every rsp_ch word against a cycle-free model of the chunk walk.
// Depends on rcl_pkg, rcl_req_if, rcl_rsp_if and the RTL under hw/rtl.
module riff_chunk_locator_top_test import rcl_pkg::*; ();

   localparam logic [RCL_WORD_W-1:0] DATA_CODE = 32'h6174_6164;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 200;
   localparam int PHASE_RESULTS = 8;

   class rcl_scoreboard;
      logic [RCL_WORD_W-1:0] target_code;
      logic [RCL_WORD_W-1:0] body_len;
      rcl_phase_type         walk_phase;
      logic [2:0]            hdr_idx;
      logic [RCL_WORD_W-1:0] code_acc;
      logic [RCL_WORD_W-1:0] size_acc;
      logic [RCL_WORD_W-1:0] skip_left;
      logic [RCL_WORD_W-1:0] byte_pos;
      rcl_result_type        expected_results[$];
      int errors;
      int found_count;
      int missing_count;

      function new();
         target_code = RCL_TARGET_RESET;
         body_len = RCL_LENGTH_RESET;
         clear_walk();
      endfunction

      function void clear_walk();
         walk_phase = PH_HEADER;
         hdr_idx = '0;
         code_acc = '0;
         size_acc = '0;
         skip_left = '0;
         byte_pos = '0;
      endfunction

      function void set_reg(logic idx, logic [RCL_WORD_W-1:0] value);
         if (idx == RCL_REG_TARGET) target_code = value;
         else body_len = value;
      endfunction

      function void push_report(logic status, logic [RCL_WORD_W-1:0] size,
                                logic [RCL_WORD_W-1:0] offset);
         rcl_result_type res;
         res.status = status;
         res.chunk_size = size;
         res.payload_offset = offset;
         expected_results.push_back(res);
         walk_phase = PH_DONE;
      endfunction

      // Returns 1 when the byte advanced the walk, 0 when it was dropped.
      function bit note_byte(rcl_byte_type word);
         logic [RCL_WORD_W-1:0] pos;
         logic [RCL_WORD_W:0]   next_start;
         if (word.first) clear_walk();
         if (walk_phase == PH_DONE) return 1'b0;
         pos = byte_pos;
         byte_pos = pos + 32'd1;
         if (walk_phase == PH_SKIP) begin
            if (skip_left != '0) skip_left = skip_left - 32'd1;
            if (skip_left == '0) walk_phase = PH_HEADER;
            return 1'b1;
         end
         if (hdr_idx == '0 && pos >= body_len) begin
            push_report(RCL_NOT_FOUND, '0, '0);
            return 1'b1;
         end
         if (hdr_idx < 3'd4) code_acc = {word.data_byte, code_acc[RCL_WORD_W-1:8]};
         else size_acc = {word.data_byte, size_acc[RCL_WORD_W-1:8]};
         if (hdr_idx != RCL_LAST_HDR_BYTE) begin
            hdr_idx = hdr_idx + 3'd1;
            return 1'b1;
         end
         hdr_idx = '0;
         if (code_acc == target_code) begin
            push_report(RCL_FOUND, size_acc, pos + 32'd1);
            return 1'b1;
         end
         next_start = {1'b0, pos} + 33'd1 + {1'b0, size_acc};
         if (next_start >= {1'b0, body_len}) begin
            push_report(RCL_NOT_FOUND, '0, '0);
         end else begin
            skip_left = size_acc;
            walk_phase = (size_acc == '0) ? PH_HEADER : PH_SKIP;
         end
         return 1'b1;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void check_result(rcl_result_type got);
         rcl_result_type want;
         if (expected_results.size() == 0) begin
            flag($sformatf("unexpected result: status %0d size %h offset %h",
                           got.status, got.chunk_size, got.payload_offset));
            return;
         end
         want = expected_results.pop_front();
         if (want.status == RCL_FOUND) found_count++;
         else missing_count++;
         if (got.status != want.status || got.chunk_size != want.chunk_size ||
             got.payload_offset != want.payload_offset)
            flag($sformatf("mismatch: expected status %0d size %h offset %h, got status %0d size %h offset %h",
                           want.status, want.chunk_size, want.payload_offset,
                           got.status, got.chunk_size, got.payload_offset));
      endfunction

      function void close();
         if (expected_results.size() != 0)
            flag($sformatf("%0d expected results never arrived", expected_results.size()));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function bit walk_done();
         return walk_phase == PH_DONE;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [RCL_ADDR_W-1:0] paddr;
   logic [RCL_WORD_W-1:0] pwdata;
   logic [RCL_WORD_W-1:0] prdata;
   logic pready;

   rcl_req_if req_ch();
   rcl_rsp_if rsp_ch();

   rcl_scoreboard board = new();

   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   int walked = 0;
   int dropped = 0;
   int settings = 0;

   riff_chunk_locator_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rcl_result_type got;
      cycle_count++;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status = rsp_ch.status;
         got.chunk_size = rsp_ch.chunk_size;
         got.payload_offset = rsp_ch.payload_offset;
         board.check_result(got);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_byte(input logic [RCL_BYTE_W-1:0] value, input logic restart);
      rcl_byte_type word;
      word.data_byte = value;
      word.first = restart;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= value;
      req_ch.first <= restart;
      do @(posedge clock); while (!req_ch.ready);
      if (board.note_byte(word)) walked++;
      else dropped++;
   endtask

   task automatic send_header(input logic [RCL_WORD_W-1:0] code,
                              input logic [RCL_WORD_W-1:0] size,
                              input logic restart, input int upto);
      logic [63:0] hdr;
      hdr = {size, code};
      for (int i = 0; i < upto; i++) begin
         send_byte(hdr[8*i +: 8], restart && i == 0);
         if (board.walk_done()) break;
      end
   endtask

   // Mostly well-formed walks; a few get cut off inside a header.
   task automatic send_walk();
      int chunks;
      int cut_chunk;
      logic [RCL_WORD_W-1:0] code;
      logic [RCL_WORD_W-1:0] size;
      chunks = $urandom_range(1, 4);
      cut_chunk = ($urandom_range(99) < 12) ? $urandom_range(0, chunks - 1) : chunks;
      for (int c = 0; c < chunks; c++) begin
         case ($urandom_range(5))
            0, 1: code = board.target_code;
            2: code = board.target_code ^ (32'h1 << $urandom_range(31));
            3: code = $urandom_range(1) ? RCL_TARGET_RESET : DATA_CODE;
            default: code = $urandom();
         endcase
         case ($urandom_range(9))
            0: size = '0;
            1: size = $urandom();
            2: size = '1;
            default: size = $urandom_range(1, 6);
         endcase
         send_header(code, size, c == 0, (c == cut_chunk) ? $urandom_range(1, 7) : 8);
         if (board.walk_done() || c == cut_chunk || size > 64) return;
         for (int i = 0; i < int'(size); i++) send_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   task automatic write_reg(input logic idx, input logic [RCL_WORD_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      board.set_reg(idx, value);
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [RCL_WORD_W-1:0] targets[6];
      logic [RCL_WORD_W-1:0] lengths[6];
      int start_walked;
      int start_results;
      bit pressure_done;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.first = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no restart after reset, empty body, then a dropped byte
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      drain();
      write_reg(RCL_REG_LENGTH, 32'd9);
      settings++;
      // zero-size chunk, then a match whose header runs past the end
      send_header('0, '0, 1'b1, 8);
      send_header(RCL_TARGET_RESET, '1, 1'b0, 8);
      // next header start lands exactly on the end
      send_header('1, 32'd1, 1'b1, 8);

      targets = '{RCL_TARGET_RESET, '0, '1, DATA_CODE, $urandom(), RCL_TARGET_RESET};
      lengths = '{32'd40, 32'd1, '1, $urandom_range(16, 64), '0, 32'd24};
      for (int p = 0; p < 6; p++) begin
         drain();
         case (p / 2)
            0: begin
               send_idle_pct = 37;
               recv_stall_pct = 52;
            end
            1: begin
               send_idle_pct = 52;
               recv_stall_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         write_reg(RCL_REG_TARGET, targets[p]);
         write_reg(RCL_REG_LENGTH, lengths[p]);
         settings++;
         start_walked = walked;
         start_results = board.found_count + board.missing_count;
         pressure_done = 1'b0;
         repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)), 1'b0);
         while (walked - start_walked < PHASE_BYTES ||
                board.found_count + board.missing_count - start_results < PHASE_RESULTS) begin
            if (!pressure_done && walked - start_walked >= 60) begin
               pressure_done = 1'b1;
               if (p == 1) hold_left = 400;
               if (p == 3) drain();
            end
            if ($urandom_range(99) < 85) send_walk();
            else send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
         end
      end
      drain();
      repeat (10) @(posedge clock);
      board.close();
      $display("Walked %0d body bytes, dropped %0d after reports, over %0d register settings;",
               walked, dropped, settings);
      $display("checked %0d chunks found and %0d bodies without a match.",
               board.found_count, board.missing_count);
      if (board.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule

// ----- filelist.f -----
hw/rtl/rcl_pkg.sv
hw/rtl/rcl_req_if.sv
hw/rtl/rcl_rsp_if.sv
hw/rtl/rcl_walker.sv
hw/rtl/riff_chunk_locator_top.sv
test/riff_chunk_locator_top_test.sv
